// ===== hw/rtl/mb_pkg.sv =====
// Package for the meshlet builder: result kinds, register indexes and the
// command/status structs between controller and datapath.
// No dependencies.
package mb_pkg;

	typedef enum logic [1:0] {
		KIND_VERT = 2'd0,
		KIND_IDX  = 2'd1,
		KIND_PAD  = 2'd2,
		KIND_DESC = 2'd3
	} kind_t;

	localparam logic [7:0] REG_MAX_VERT = 8'd0;
	localparam logic [7:0] REG_MAX_PRIM = 8'd1;

	localparam logic [6:0] MAX_VERT_RST = 7'd64;
	localparam logic [7:0] MAX_PRIM_RST = 8'd124;

	typedef struct packed {
		logic       load;       // take input request
		logic       scan;       // advance table scan
		logic       clr_loc;    // close decided: drop matches, load pad count
		logic       emit_pad;
		logic       emit_desc;
		logic       desc_last;
		logic       close_upd;  // advance bases, empty meshlet
		logic       append;     // write new vertex of slot, emit it
		logic       emit_idx;
		logic       tri_done;
		logic       flush;
		logic [1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic scan_done;
		logic close;
		logic has_pad;
		logic pad_last;
		logic found_slot;
		logic nonempty;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/meshlet_builder.sv =====
// Top level of the meshlet builder: controller and datapath.
// Depends on mb_pkg, mb_ctrl and mb_dpath.
//
//  channel  direction  payload
//  s_*      in         tuser: mode; tdata: vertex_a, vertex_b, vertex_c
//  m_*      out        tuser: kind; tlast: last; tdata: descriptor/value
//  cfg_*    in         cfg_index: register, cfg_data: value (always ready)
//
// A triangle goes through an accept step, a table scan (V = unique vertices
// held, one memory read a cycle), a decide step, then one output per pad byte
// and descriptor, one step per vertex slot (three, matched or new) and one
// output per index byte; a finish request is accepted, then flushed.
// Reset clears all counters and sets the limits to 64 and 124; the vertex
// table needs no clearing. A stalled m_tready holds the machine at the next
// result; the last result waits in the output register while a request is taken.
module meshlet_builder #(
	parameter int TABLE_DEPTH = 64,
	parameter int PAD_ALIGN   = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // vertex_a, vertex_b, vertex_c
	input  logic         s_tuser,   // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // value, meshlet_vertex_begin,
	                                // meshlet_primitive_begin, meshlet_vertex_count,
	                                // meshlet_prim_vert_count, zero fill
	output logic [1:0]   m_tuser,   // kind
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [7:0]   cfg_data
);
	import mb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mb_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PAD_ALIGN   (PAD_ALIGN)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hw/rtl/mb_ctrl.sv =====
// Controller state machine of the meshlet builder.
// Depends on mb_pkg; drives mb_dpath through cmd_t, watches sts_t.
module mb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  mb_pkg::sts_t  sts,
	output mb_pkg::cmd_t  cmd
);
	import mb_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_PAD    = 8'b0000_1000,
		S_DESC   = 8'b0001_0000,
		S_APPEND = 8'b0010_0000,
		S_IDX    = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] slot_q, slot_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		slot_d  = slot_q;
		cmd     = '0;
		cmd.slot = slot_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = sts.mode ? S_FIN : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				slot_d = 2'd0;
				if (sts.close) begin
					cmd.clr_loc = 1'b1;
					state_d = sts.has_pad ? S_PAD : S_DESC;
				end else begin
					state_d = S_APPEND;
				end
			end
			S_PAD: begin
				if (sts.out_free) begin
					cmd.emit_pad = 1'b1;
					if (sts.pad_last) state_d = S_DESC;
				end
			end
			S_DESC: begin
				if (sts.out_free) begin
					cmd.emit_desc = 1'b1;
					cmd.close_upd = 1'b1;
					state_d = S_APPEND;
				end
			end
			S_APPEND: begin
				// skip matched slots without waiting for the output
				if (sts.found_slot || sts.out_free) begin
					cmd.append = !sts.found_slot;
					if (slot_q == 2'd2) begin
						slot_d  = 2'd0;
						state_d = S_IDX;
					end else begin
						slot_d = slot_q + 2'd1;
					end
				end
			end
			S_IDX: begin
				if (sts.out_free) begin
					cmd.emit_idx = 1'b1;
					if (slot_q == 2'd2) begin
						cmd.tri_done = 1'b1;
						slot_d  = 2'd0;
						state_d = S_IDLE;
					end else begin
						slot_d = slot_q + 2'd1;
					end
				end
			end
			S_FIN: begin
				if (!sts.nonempty) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit_desc = 1'b1;
					cmd.desc_last = 1'b1;
					cmd.flush     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
		end
	end

endmodule

// ===== hw/rtl/mb_dpath.sv =====
// Datapath of the meshlet builder: configuration, vertex table memory,
// scan compare, meshlet counters and the output register. Depends on mb_pkg.
module mb_dpath #(
	parameter int TABLE_DEPTH = 64,
	parameter int PAD_ALIGN   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [7:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic [95:0]   s_tdata,
	input  logic          s_tuser,
	input  mb_pkg::cmd_t  cmd,
	output mb_pkg::sts_t  sts,
	input  logic          m_tready,
	output logic          m_tvalid,
	output logic [119:0]  m_tdata,
	output logic [1:0]    m_tuser,
	output logic          m_tlast
);
	import mb_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int DW = (PAD_ALIGN > 1) ? $clog2(PAD_ALIGN) : 1;
	localparam int XW = $clog2(4 * PAD_ALIGN) + 1;

	logic [31:0]   vtx_q [3];
	logic [6:0]    max_vert_q;
	logic [7:0]    max_prim_q;
	logic [31:0]   table_mem [TABLE_DEPTH];
	logic [31:0]   rd_data_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_valid_s1;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] vcount_q;
	logic [9:0]    prim_q;
	logic [DW-1:0] deficit_q;
	logic [DW-1:0] pad_cnt_q;
	logic [31:0]   vbase_q, pbase_q;
	logic [2:0]    found_q;
	logic [IW-1:0] loc_q [3];

	logic          valid_q;
	kind_t         kind_q;
	logic [31:0]   value_q, ovb_q, opb_q;
	logic [6:0]    ovc_q;
	logic [9:0]    opc_q;
	logic          last_q;

	logic          rd_en;
	logic [9:0]    padded, mp3, lim, mv10, need;
	logic [1:0]    fresh;
	logic          emit;

	// deficit of the padded count after three more primitive vertices
	function automatic logic [DW-1:0] next_deficit(input logic [DW-1:0] d);
		logic [XW-1:0] x;
		x = XW'(d) + XW'(3 * PAD_ALIGN - 3);
		for (int k = 0; k < 3; k++)
			if (x >= XW'(PAD_ALIGN)) x = x - XW'(PAD_ALIGN);
		return DW'(x);
	endfunction

	assign rd_en  = cmd.scan && (scan_q != vcount_q);
	assign padded = prim_q + 10'(deficit_q);
	assign mp3    = {1'b0, max_prim_q, 1'b0} + 10'(max_prim_q);
	assign mv10   = 10'(max_vert_q);
	assign lim    = (mv10 < 10'd3) ? 10'd3 :
	                (mv10 > 10'(TABLE_DEPTH)) ? 10'(TABLE_DEPTH) : mv10;
	assign fresh  = 2'(!found_q[0]) + 2'(!found_q[1]) + 2'(!found_q[2]);
	assign need   = 10'(vcount_q) + 10'(fresh);
	assign emit   = cmd.emit_pad | cmd.emit_desc | cmd.append | cmd.emit_idx;

	always_comb begin
		sts            = '0;
		sts.mode       = s_tuser;
		sts.scan_done  = !rd_valid_s1 && (scan_q == vcount_q);
		sts.close      = (padded > mp3) || (need > lim);
		sts.has_pad    = (deficit_q != '0);
		sts.pad_last   = (pad_cnt_q == DW'(1));
		sts.found_slot = found_q[cmd.slot];
		sts.nonempty   = (vcount_q != '0) && (prim_q != '0);
		sts.out_free   = !valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vert_q <= MAX_VERT_RST;
			max_prim_q <= MAX_PRIM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_VERT: max_vert_q <= cfg_data[6:0];
				REG_MAX_PRIM: max_prim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// vertex table: one write or one read a cycle, read data registered
	always_ff @(posedge clk) begin
		if (cmd.append) table_mem[vcount_q[IW-1:0]] <= vtx_q[cmd.slot];
		if (rd_en) rd_data_s1 <= table_mem[scan_q[IW-1:0]];
		rd_idx_s1 <= scan_q[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vtx_q[0] <= s_tdata[31:0];
			vtx_q[1] <= s_tdata[63:32];
			vtx_q[2] <= s_tdata[95:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			scan_q      <= '0;
			found_q     <= '0;
			vcount_q    <= '0;
			prim_q      <= '0;
			deficit_q   <= '0;
			pad_cnt_q   <= '0;
			vbase_q     <= '0;
			pbase_q     <= '0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_en) scan_q <= scan_q + CW'(1);
			if (cmd.load) begin
				scan_q  <= '0;
				found_q <= '0;
			end
			if (rd_valid_s1) begin
				for (int j = 0; j < 3; j++)
					if (!found_q[j] && rd_data_s1 == vtx_q[j]) found_q[j] <= 1'b1;
			end
			if (cmd.clr_loc) begin
				found_q   <= '0;
				pad_cnt_q <= deficit_q;
			end
			if (cmd.emit_pad) pad_cnt_q <= pad_cnt_q - DW'(1);
			if (cmd.close_upd) begin
				vbase_q   <= vbase_q + 32'(vcount_q);
				pbase_q   <= pbase_q + 32'(padded);
				vcount_q  <= '0;
				prim_q    <= '0;
				deficit_q <= '0;
			end
			if (cmd.append) vcount_q <= vcount_q + CW'(1);
			if (cmd.tri_done) begin
				prim_q    <= prim_q + 10'd3;
				deficit_q <= next_deficit(deficit_q);
			end
			if (cmd.flush) begin
				vcount_q  <= '0;
				prim_q    <= '0;
				deficit_q <= '0;
				vbase_q   <= '0;
				pbase_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			for (int j = 0; j < 3; j++)
				if (!found_q[j] && rd_data_s1 == vtx_q[j]) loc_q[j] <= rd_idx_s1;
		end
		if (cmd.append) loc_q[cmd.slot] <= vcount_q[IW-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (emit) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q <= '0;
			ovb_q   <= '0;
			opb_q   <= '0;
			ovc_q   <= '0;
			opc_q   <= '0;
			last_q  <= cmd.desc_last || (cmd.emit_idx && cmd.slot == 2'd2);
			if (cmd.emit_pad) kind_q <= KIND_PAD;
			if (cmd.emit_desc) begin
				kind_q <= KIND_DESC;
				ovb_q  <= vbase_q;
				opb_q  <= pbase_q;
				ovc_q  <= 7'(vcount_q);
				opc_q  <= prim_q;
			end
			if (cmd.append) begin
				kind_q  <= KIND_VERT;
				value_q <= vtx_q[cmd.slot];
			end
			if (cmd.emit_idx) begin
				kind_q  <= KIND_IDX;
				value_q <= 32'(loc_q[cmd.slot]);
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, opc_q, ovc_q, opb_q, ovb_q, value_q};

endmodule

// ===== hw/rtl/mb_checker.sv =====
// Port-level checks for meshlet_builder, bound to the top level.
// Depends on mb_pkg.
module mb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);
	import mb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_desc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_DESC |-> m_tdata[119:32] == '0)
		else $error("descriptor fields set on non-descriptor");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAD |-> !m_tlast && m_tdata == '0)
		else $error("bad pad byte");

endmodule

bind meshlet_builder mb_checker u_mb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
